FILE: hw/rtl/pixel_replicate_upscaler_unit_defines.svh
// Assertion macros shared by the pixel replicate upscaler RTL.
`ifndef PIXEL_REPLICATE_UPSCALER_UNIT_DEFINES_SVH
`define PIXEL_REPLICATE_UPSCALER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PRU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pru assertion failed");
`define PRU_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("pru forbidden condition seen");
`else
`define PRU_ASSERT(lbl, clk, rstn, prop)
`define PRU_NEVER(lbl, clk, rstn, expr)
`endif
`endif

FILE: hw/rtl/pru_pkg.sv
// Types and constants shared by the pixel replicate upscaler modules.
`default_nettype none
package pru_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_SCALE = 16;

  localparam int SCALE_FIELD_W = 5;
  localparam int WIDTH_FIELD_W = 11;
  localparam int CFG_DATA_W    = WIDTH_FIELD_W;
  localparam int CFG_IDX_W     = 1;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int FILL_W = WIDTH_FIELD_W;
  localparam int COPY_W = 4;
  localparam int REP_W  = 5;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 1'b1;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_PULL  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_PAD     = 2'd1,
    KIND_IDLE    = 2'd2,
    KIND_REFUSED = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    kind_t kind;
    logic  line_end;
    logic  group_end;
  } result_cmd_t;

  typedef struct packed {
    result_cmd_t cmd;
    pixel_t      pix;
  } q_entry_t;

endpackage
`default_nettype wire

FILE: hw/rtl/pru_front.sv
// Front end: configuration, item classification, counters and the line store.
`default_nettype none
`include "pixel_replicate_upscaler_unit_defines.svh"
module pru_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [pru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pru_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_room_i,
  input  wire logic                          in_op_i,
  input  wire pru_pkg::pixel_t               in_pix_i,
  output logic                               in_stall_o,
  output logic                               res_valid_o,
  output pru_pkg::result_cmd_t               res_cmd_o,
  output pru_pkg::pixel_t                    res_pix_o
);
  import pru_pkg::*;

  logic [SCALE_FIELD_W-1:0] scale_r;
  logic [WIDTH_FIELD_W-1:0] width_r;

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              emitting_r, emitting_nxt;
  logic [COL_W-1:0]  src_r, src_nxt;
  logic [COPY_W-1:0] copy_r, copy_nxt;
  logic [1:0]        pad_r, pad_nxt;
  logic [REP_W-1:0]  rep_r, rep_nxt;

  logic        s1_valid_r, s1_valid_nxt;
  result_cmd_t s1_cmd_r, s1_cmd_nxt;
  logic        s1_res;

  logic [SCALE_FIELD_W-1:0] eff_s;
  logic [WIDTH_FIELD_W-1:0] eff_w;
  logic                     accept;

  logic [SCALE_FIELD_W-1:0] cc1;
  logic [FILL_W-1:0]        sc1;
  logic [FILL_W-1:0]        fill1;
  logic [REP_W:0]           r1;
  logic [1:0]               row_pad;
  logic                     row_done;

  logic             wr_en, rd_en;
  logic [COL_W-1:0] wr_addr;
  pixel_t           mem [MAX_WIDTH];
  pixel_t           rd_q_r;

  assign eff_s = (scale_r == '0) ? SCALE_FIELD_W'(1) :
                 (scale_r > SCALE_FIELD_W'(MAX_SCALE)) ? SCALE_FIELD_W'(MAX_SCALE) : scale_r;
  assign eff_w = (width_r == '0) ? WIDTH_FIELD_W'(1) :
                 (width_r > WIDTH_FIELD_W'(MAX_WIDTH)) ? WIDTH_FIELD_W'(MAX_WIDTH) : width_r;

  assign in_stall_o = !in_room_i;
  assign accept     = in_valid_i && in_room_i;

  assign cc1     = {{(SCALE_FIELD_W-COPY_W){1'b0}}, copy_r} + SCALE_FIELD_W'(1);
  assign sc1     = {{(FILL_W-COL_W){1'b0}}, src_r} + FILL_W'(1);
  assign fill1   = fill_r + FILL_W'(1);
  assign r1      = {1'b0, rep_r} + (REP_W+1)'(1);
  // Only the two low bits of width and scale matter for the product mod 4.
  assign row_pad = eff_w[1:0] * eff_s[1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_FIELD_W'(1);
      width_r <= WIDTH_FIELD_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE: scale_r <= cfg_data[SCALE_FIELD_W-1:0];
        CFG_WIDTH: width_r <= cfg_data[WIDTH_FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    fill_nxt     = fill_r;
    emitting_nxt = emitting_r;
    src_nxt      = src_r;
    copy_nxt     = copy_r;
    pad_nxt      = pad_r;
    rep_nxt      = rep_r;
    s1_res       = 1'b0;
    s1_cmd_nxt   = '{kind: KIND_IDLE, line_end: 1'b0, group_end: 1'b0};
    row_done     = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    wr_addr      = fill_r[COL_W-1:0];

    if (accept) begin
      if (op_t'(in_op_i) == OP_PIXEL) begin
        if (emitting_r) begin
          s1_res          = 1'b1;
          s1_cmd_nxt.kind = KIND_REFUSED;
        end else begin
          wr_en    = (fill_r < FILL_W'(MAX_WIDTH));
          fill_nxt = fill1;
          if (fill1 >= eff_w) begin
            emitting_nxt = 1'b1;
            src_nxt      = '0;
            copy_nxt     = '0;
            pad_nxt      = '0;
            rep_nxt      = '0;
          end
        end
      end else if (!emitting_r) begin
        s1_res          = 1'b1;
        s1_cmd_nxt.kind = KIND_IDLE;
      end else begin
        s1_res = 1'b1;
        if (pad_r != '0) begin
          s1_cmd_nxt.kind = KIND_PAD;
          pad_nxt         = pad_r - 2'd1;
          row_done        = (pad_r == 2'd1);
        end else begin
          s1_cmd_nxt.kind = KIND_PIXEL;
          rd_en           = 1'b1;
          if (cc1 >= eff_s) begin
            copy_nxt = '0;
            if (sc1 >= eff_w) begin
              src_nxt  = '0;
              pad_nxt  = row_pad;
              row_done = (row_pad == 2'd0);
            end else begin
              src_nxt = sc1[COL_W-1:0];
            end
          end else begin
            copy_nxt = cc1[COPY_W-1:0];
          end
        end

        if (row_done) begin
          if (r1 >= {1'b0, eff_s}) begin
            s1_cmd_nxt.group_end = 1'b1;
            rep_nxt      = '0;
            emitting_nxt = 1'b0;
            fill_nxt     = '0;
            src_nxt      = '0;
            copy_nxt     = '0;
            pad_nxt      = '0;
          end else begin
            rep_nxt = r1[REP_W-1:0];
          end
        end
        s1_cmd_nxt.line_end = row_done;
      end
    end
    s1_valid_nxt = s1_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      emitting_r <= 1'b0;
      src_r      <= '0;
      copy_r     <= '0;
      pad_r      <= '0;
      rep_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      emitting_r <= emitting_nxt;
      src_r      <= src_nxt;
      copy_r     <= copy_nxt;
      pad_r      <= pad_nxt;
      rep_r      <= rep_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd_r <= s1_cmd_nxt;
  end

  // Line store: one write port for filling, one registered read for emitting.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_pix_i;
    end
    if (rd_en) begin
      rd_q_r <= mem[src_r];
    end
  end

  assign res_valid_o = s1_valid_r;
  assign res_cmd_o   = s1_cmd_r;
  assign res_pix_o   = (s1_cmd_r.kind == KIND_PIXEL) ? rd_q_r : '0;

  `PRU_NEVER(a_pad_only_emitting, clk, rst_n, (pad_r != 2'd0) && !emitting_r)
  `PRU_ASSERT(a_group_ends_line, clk, rst_n, res_valid_o && res_cmd_o.group_end |-> res_cmd_o.line_end)
  `PRU_NEVER(a_copy_below_max, clk, rst_n, {1'b0, copy_r} >= (COPY_W+1)'(MAX_SCALE))

endmodule
`default_nettype wire

FILE: hw/rtl/pru_back.sv
// Back end: result queue that decouples the front end from the output channel.
`default_nettype none
`include "pixel_replicate_upscaler_unit_defines.svh"
module pru_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push_i,
  input  wire pru_pkg::result_cmd_t push_cmd_i,
  input  wire pru_pkg::pixel_t      push_pix_i,
  output logic                      room_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output pru_pkg::result_cmd_t      out_cmd_o,
  output pru_pkg::pixel_t           out_pix_o
);
  import pru_pkg::*;

  q_entry_t             q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 pop;
  q_entry_t             head;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (count_r != '0);
  assign head        = q_r[rd_ptr_r];
  assign out_cmd_o   = head.cmd;
  assign out_pix_o   = head.pix;

  // A result launched this cycle lands next cycle, so count it as taken.
  assign room_o = ({1'b0, count_r} + {{Q_CNT_W{1'b0}}, push_i}) < (Q_CNT_W+1)'(Q_DEPTH);

  always_comb begin
    wr_ptr_nxt = push_i ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push_i) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      q_r[wr_ptr_r] <= '{cmd: push_cmd_i, pix: push_pix_i};
    end
  end

  `PRU_NEVER(a_no_overflow, clk, rst_n, push_i && !pop && (count_r == Q_CNT_W'(Q_DEPTH)))
  `PRU_NEVER(a_count_bound, clk, rst_n, count_r > Q_CNT_W'(Q_DEPTH))

endmodule
`default_nettype wire

FILE: hw/rtl/pixel_replicate_upscaler_unit.sv
// Top level of the pixel replicate upscaler: front end, line store and result queue.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_stall    in_op, in_blue, in_green, in_red
//   out       output     out_valid / out_stall  out_kind, out_blue, out_green,
//                                               out_red, out_line_end, out_group_end
//   cfg       input      cfg_we                 cfg_index, cfg_data
//
// One item is accepted per clock while in_stall is low. A result is registered on its
// way to the outputs: one register stage holds the line store read and the command,
// the next is the result queue.
// The four-entry result queue absorbs output stalls; in_stall rises when the queued
// results plus the one held in the front register would fill it.
// Reset is synchronous and active low; it restores scale 1, width 1 and filling.
// The line store needs no clearing and the block takes items right after reset.
`default_nettype none
module pixel_replicate_upscaler_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [pru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pru_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_op,
  input  wire logic [7:0]                    in_blue,
  input  wire logic [7:0]                    in_green,
  input  wire logic [7:0]                    in_red,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_kind,
  output logic [7:0]                         out_blue,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_red,
  output logic                               out_line_end,
  output logic                               out_group_end
);
  import pru_pkg::*;

  pixel_t      in_pix;
  logic        room;
  logic        res_valid;
  result_cmd_t res_cmd;
  pixel_t      res_pix;
  result_cmd_t q_cmd;
  pixel_t      q_pix;

  assign in_pix = '{red: in_red, green: in_green, blue: in_blue};

  pru_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid_i  (in_valid),
    .in_room_i   (room),
    .in_op_i     (in_op),
    .in_pix_i    (in_pix),
    .in_stall_o  (in_stall),
    .res_valid_o (res_valid),
    .res_cmd_o   (res_cmd),
    .res_pix_o   (res_pix)
  );

  pru_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (res_valid),
    .push_cmd_i  (res_cmd),
    .push_pix_i  (res_pix),
    .room_o      (room),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_cmd_o   (q_cmd),
    .out_pix_o   (q_pix)
  );

  assign out_kind      = q_cmd.kind;
  assign out_line_end  = q_cmd.line_end;
  assign out_group_end = q_cmd.group_end;
  assign out_blue      = q_pix.blue;
  assign out_green     = q_pix.green;
  assign out_red       = q_pix.red;

endmodule
`default_nettype wire

FILE: dv/pixel_replicate_upscaler_unit_test.sv
// Self-checking testbench for the pixel replicate upscaler with a built-in row replication predictor.
`timescale 1ns / 1ps
module pixel_replicate_upscaler_unit_test;
  import pru_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_ITEMS   = 250;
  localparam int TIMEOUT_CYCLES = 1_000_000;

  typedef struct {
    op_t    op;
    pixel_t pix;
  } source_item_t;

  typedef struct {
    kind_t  kind;
    pixel_t pix;
    logic   line_end;
    logic   group_end;
  } upscaled_item_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic                  in_op     = 1'b0;
  logic [7:0]            in_blue   = '0;
  logic [7:0]            in_green  = '0;
  logic [7:0]            in_red    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_kind;
  logic [7:0]            out_blue;
  logic [7:0]            out_green;
  logic [7:0]            out_red;
  logic                  out_line_end;
  logic                  out_group_end;

  source_item_t   source_items[$];
  upscaled_item_t upscaled_due[$];
  int             queued_count = 0;
  int             err_count    = 0;

  // Predictor state, mirroring the block's registers and counters.
  pixel_t                 src_row[MAX_WIDTH];
  bit                     src_row_set[MAX_WIDTH];
  logic [SCALE_FIELD_W-1:0] reg_scale = SCALE_FIELD_W'(1);
  logic [WIDTH_FIELD_W-1:0] reg_width = WIDTH_FIELD_W'(1);
  int  fill_col   = 0;
  bit  emit_phase = 1'b0;
  int  src_col    = 0;
  int  copies     = 0;
  int  pad_owed   = 0;
  int  rows_done  = 0;

  pixel_replicate_upscaler_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_blue       (in_blue),
    .in_green      (in_green),
    .in_red        (in_red),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_blue      (out_blue),
    .out_green     (out_green),
    .out_red       (out_red),
    .out_line_end  (out_line_end),
    .out_group_end (out_group_end)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int eff_scale();
    if (reg_scale == 0) return 1;
    if (reg_scale > MAX_SCALE) return MAX_SCALE;
    return reg_scale;
  endfunction

  function automatic int eff_width();
    if (reg_width == 0) return 1;
    if (reg_width > MAX_WIDTH) return MAX_WIDTH;
    return reg_width;
  endfunction

  // Number of leading line store entries that hold a written pixel.
  function automatic int written_prefix();
    int n;
    n = 0;
    while (n < MAX_WIDTH && src_row_set[n]) n++;
    return n;
  endfunction

  task automatic replicate_step(input op_t op, input pixel_t pix);
    int             w;
    int             s;
    upscaled_item_t r;
    w = eff_width();
    s = eff_scale();
    r.kind      = KIND_IDLE;
    r.pix       = '0;
    r.line_end  = 1'b0;
    r.group_end = 1'b0;
    if (op == OP_PIXEL) begin
      if (emit_phase) begin
        r.kind = KIND_REFUSED;
        upscaled_due.push_back(r);
      end else begin
        if (fill_col < MAX_WIDTH) begin
          src_row[fill_col]     = pix;
          src_row_set[fill_col] = 1'b1;
        end
        fill_col++;
        if (fill_col >= w) begin
          emit_phase = 1'b1;
          src_col    = 0;
          copies     = 0;
          pad_owed   = 0;
          rows_done  = 0;
        end
      end
    end else if (!emit_phase) begin
      upscaled_due.push_back(r);
    end else begin
      if (pad_owed != 0) begin
        r.kind = KIND_PAD;
        pad_owed--;
        r.line_end = (pad_owed == 0);
      end else begin
        r.kind = KIND_PIXEL;
        r.pix  = src_row[src_col];
        copies++;
        if (copies >= s) begin
          copies = 0;
          src_col++;
          if (src_col >= w) begin
            src_col    = 0;
            pad_owed   = (w * s) % 4;
            r.line_end = (pad_owed == 0);
          end
        end
      end
      if (r.line_end) begin
        rows_done++;
        if (rows_done >= s) begin
          r.group_end = 1'b1;
          rows_done   = 0;
          emit_phase  = 1'b0;
          fill_col    = 0;
          src_col     = 0;
          copies      = 0;
          pad_owed    = 0;
        end
      end
      upscaled_due.push_back(r);
    end
  endtask

  task automatic push_source(input op_t op, input pixel_t pix);
    source_item_t it;
    it.op  = op;
    it.pix = pix;
    source_items.push_back(it);
    queued_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SCALE) reg_scale = val[SCALE_FIELD_W-1:0];
    else reg_width = val;
  endtask

  // Waits until every queued transaction is accepted and answered, then lets
  // the pipeline settle so that a stored pixel cannot still be in flight.
  task automatic wait_drained();
    do @(negedge clk);
    while (source_items.size() != 0 || in_valid || upscaled_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  // Driver: sends in bursts separated by random gaps.
  int           burst_left = 0;
  int           gap_left   = 0;
  source_item_t nxt;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        replicate_step(op_t'(in_op), pixel_t'({in_red, in_green, in_blue}));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (source_items.size() > 0) begin
          nxt = source_items.pop_front();
          in_valid <= 1'b1;
          in_op    <= nxt.op;
          in_red   <= nxt.pix.red;
          in_green <= nxt.pix.green;
          in_blue  <= nxt.pix.blue;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: the mode is redrawn at random from the four stall modes.
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_tick = 0;

  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 64 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 1) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 4) != 0);
      default:     out_stall <= (stall_tick % 8 < 3);
    endcase
  end

  // Monitor: compares each accepted result with the oldest expectation.
  upscaled_item_t got_exp;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (upscaled_due.size() == 0) begin
        $error("unexpected result transaction, kind %0d", out_kind);
        err_count++;
      end else begin
        got_exp = upscaled_due.pop_front();
        check_field("kind", 8'(got_exp.kind), 8'(out_kind));
        check_field("blue", got_exp.pix.blue, out_blue);
        check_field("green", got_exp.pix.green, out_green);
        check_field("red", got_exp.pix.red, out_red);
        check_field("line_end", 8'(got_exp.line_end), 8'(out_line_end));
        check_field("group_end", 8'(got_exp.group_end), 8'(out_group_end));
      end
    end
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int                    rand_start;
    int                    w;
    int                    s;
    int                    n_fill;
    int                    n_pull;
    int                    pick;
    int                    lim;
    bit                    first_phase;
    bit                    do_scale;
    bit                    do_width;
    logic [CFG_DATA_W-1:0] cfg_val;
    pixel_t                px;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: pull while filling, refused pixel, single pad byte.
    push_source(OP_PULL, '0);
    push_source(OP_PIXEL, 24'h000000);
    push_source(OP_PIXEL, 24'hFFFFFF);
    push_source(OP_PULL, '0);
    push_source(OP_PULL, '0);
    push_source(OP_PULL, '0);
    wait_drained();

    // Scale two on a one-pixel row gives two pad bytes per output row.
    write_reg(CFG_SCALE, CFG_DATA_W'(2));
    write_reg(CFG_WIDTH, CFG_DATA_W'(1));
    push_source(OP_PIXEL, 24'hFF00A5);
    push_source(OP_PULL, '0);
    push_source(OP_PULL, '0);
    push_source(OP_PIXEL, 24'h5AFF00);
    repeat (6) push_source(OP_PULL, '0);
    wait_drained();

    // Widest row, partly emitted; the next settings change lands mid-row.
    cfg_val = '1;
    cfg_val[SCALE_FIELD_W-1:0] = SCALE_FIELD_W'(1);
    write_reg(CFG_SCALE, cfg_val);
    write_reg(CFG_WIDTH, '1);
    repeat (MAX_WIDTH) begin
      px = 24'($urandom());
      push_source(OP_PIXEL, px);
    end
    repeat (64) push_source(OP_PULL, '0);
    wait_drained();

    rand_start  = queued_count;
    first_phase = 1'b1;
    while (queued_count < rand_start + RANDOM_ITEMS) begin
      do_scale = first_phase || $urandom_range(0, 1);
      if (do_scale) begin
        case ($urandom_range(0, 9))
          0:       pick = 0;
          1:       pick = MAX_SCALE;
          2:       pick = $urandom_range(MAX_SCALE + 1, 31);
          default: pick = $urandom_range(1, 5);
        endcase
        cfg_val = CFG_DATA_W'($urandom());
        cfg_val[SCALE_FIELD_W-1:0] = SCALE_FIELD_W'(pick);
        write_reg(CFG_SCALE, cfg_val);
      end

      // Large scales are only paired with the narrowest rows to bound run time.
      do_width = first_phase || $urandom_range(0, 1) || (eff_scale() >= 8 && eff_width() > 2);
      if (do_width) begin
        case ($urandom_range(0, 7))
          0:       pick = 0;
          1:       pick = $urandom_range(9, 24);
          default: pick = $urandom_range(1, 8);
        endcase
        if (eff_scale() >= 8 && pick > 2) pick = $urandom_range(1, 2);
        // While emitting, the row may only grow over entries already written.
        if (emit_phase && pick > written_prefix()) begin
          lim  = (written_prefix() < 8) ? written_prefix() : 8;
          pick = $urandom_range(1, lim);
        end
        write_reg(CFG_WIDTH, CFG_DATA_W'(pick));
      end
      first_phase = 1'b0;

      if ($urandom_range(0, 7) == 0) begin
        repeat (24) begin
          px = 24'($urandom());
          push_source(($urandom_range(0, 1) == 0) ? OP_PIXEL : OP_PULL, px);
        end
      end else begin
        w = eff_width();
        s = eff_scale();
        n_fill = emit_phase ? 0 : w - fill_col;
        if (!emit_phase && n_fill < 1) n_fill = 1;
        n_pull = (w * s + (w * s) % 4) * s;
        if ($urandom_range(0, 3) == 0) n_pull = $urandom_range(0, n_pull);
        repeat (n_fill) begin
          if ($urandom_range(0, 7) == 0) push_source(OP_PULL, '0);
          px = 24'($urandom());
          push_source(OP_PIXEL, px);
        end
        repeat (n_pull) begin
          if ($urandom_range(0, 9) == 0) begin
            px = 24'($urandom());
            push_source(OP_PIXEL, px);
          end
          push_source(OP_PULL, '0);
        end
      end
      wait_drained();
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
